// ===== hdl/int8_dot_8row_row_scaled_macros.svh =====
// assertion macros shared by the checker files
// no dependencies
`ifndef INT8_DOT_8ROW_ROW_SCALED_MACROS_SVH
`define INT8_DOT_8ROW_ROW_SCALED_MACROS_SVH

// condition implies consequence in the same cycle
`define IDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define IDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ids_pkg.sv =====
// shared types, widths and helper functions for the int8 scaled dot block
// no dependencies
package ids_pkg;

    localparam int ACC_W = 28;
    localparam int FP_W  = 32;
    localparam int W_W   = 8;
    localparam int ROW_W = 3;
    localparam int MAX_ROWS = 8;

    localparam logic [FP_W-1:0] FP_QNAN = 32'h7FC0_0000;

    typedef struct packed {
        logic add;
        logic shift;
        logic load;
    } cell_ctrl_t;

    // leading zero count over 28 bits
    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] n;
        logic       found;
        n = '0;
        found = 1'b0;
        for (int i = 27; i >= 0; i--)
        begin
            if (!found)
            begin
                if (v[i])
                    found = 1'b1;
                else
                    n = n + 5'd1;
            end
        end
        return n;
    endfunction

endpackage

// ===== hdl/ids_cell.sv =====
// one row cell: accumulator and row scale, shifts toward row 0 during drain
// depends on ids_pkg
module ids_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ids_pkg::cell_ctrl_t               ctrl,
    input  logic signed [ids_pkg::W_W-1:0]    act,
    input  logic signed [ids_pkg::W_W-1:0]    w,
    input  logic        [ids_pkg::FP_W-1:0]   scale_data,
    input  logic        [ids_pkg::ACC_W-1:0]  acc_in,
    input  logic        [ids_pkg::FP_W-1:0]   scale_in,
    output logic        [ids_pkg::ACC_W-1:0]  acc,
    output logic        [ids_pkg::FP_W-1:0]   scale
);
    import ids_pkg::*;

    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [FP_W-1:0]         scale_reg, scale_next;
    logic signed [2*W_W-1:0] prod;

    assign prod = w * act;

    always_comb
    begin
        acc_next = acc_reg;
        scale_next = scale_reg;
        if (ctrl.shift)
        begin
            acc_next = acc_in;
            scale_next = scale_in;
        end
        else
        begin
            if (ctrl.add)
                acc_next = acc_reg + ACC_W'(prod);
            if (ctrl.load)
                scale_next = scale_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            scale_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            scale_reg <= scale_next;
        end
    end

    assign acc = acc_reg;
    assign scale = scale_reg;

endmodule

// ===== hdl/ids_fmul.sv =====
// three-stage fp32 multiplier, round to nearest even, subnormals kept
// depends on ids_pkg
module ids_fmul #(
    parameter int TAG_W = 31
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ids_pkg::FP_W-1:0]    a,
    input  logic [ids_pkg::FP_W-1:0]    b,
    input  logic [TAG_W-1:0]            in_tag,
    output logic                        res_valid,
    output logic [ids_pkg::FP_W-1:0]    res,
    output logic [TAG_W-1:0]            res_tag
);
    import ids_pkg::*;

    // stage 1: unpack and normalize subnormal inputs
    logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
    logic [23:0]       ma, mb;
    logic [4:0]        lza, lzb;
    logic [7:0]        ea_eff, eb_eff;
    logic signed [10:0] expa, expb;
    logic              spec;
    logic [FP_W-1:0]   spec_bits;

    assign sgn    = a[31] ^ b[31];
    assign a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    assign b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    assign a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    assign b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    assign a_zero = (a[30:0] == '0);
    assign b_zero = (b[30:0] == '0);
    assign lza    = lzc28({a[30:23] != 8'd0, a[22:0], 4'hF});
    assign lzb    = lzc28({b[30:23] != 8'd0, b[22:0], 4'hF});
    assign ma     = 24'({a[30:23] != 8'd0, a[22:0]} << lza);
    assign mb     = 24'({b[30:23] != 8'd0, b[22:0]} << lzb);
    assign ea_eff = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    assign eb_eff = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    assign expa   = $signed({3'b000, ea_eff}) - $signed({6'd0, lza});
    assign expb   = $signed({3'b000, eb_eff}) - $signed({6'd0, lzb});

    always_comb
    begin
        spec = 1'b1;
        spec_bits = {sgn, 31'd0};
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
            spec_bits = FP_QNAN;
        else if (a_inf || b_inf)
            spec_bits = {sgn, 8'hFF, 23'd0};
        else if (a_zero || b_zero)
            spec_bits = {sgn, 31'd0};
        else
            spec = 1'b0;
    end

    logic               s1_valid_reg;
    logic [TAG_W-1:0]   s1_tag_reg;
    logic               s1_sgn_reg, s1_spec_reg;
    logic [FP_W-1:0]    s1_spec_bits_reg;
    logic [23:0]        s1_ma_reg, s1_mb_reg;
    logic signed [10:0] s1_e_reg;

    // stage 2: significand product
    logic               s2_valid_reg;
    logic [TAG_W-1:0]   s2_tag_reg;
    logic               s2_sgn_reg, s2_spec_reg;
    logic [FP_W-1:0]    s2_spec_bits_reg;
    logic [47:0]        s2_prod_reg;
    logic signed [10:0] s2_e_reg;

    // stage 3: normalize, denormalize, round, pack
    logic signed [10:0] e1;
    logic [47:0]        sig, shifted, lost_mask;
    logic [5:0]         sh;
    logic               normal, g, st, inc;
    logic [23:0]        mant24;
    logic [24:0]        mant25;
    logic [9:0]         base;
    logic [33:0]        pack;
    logic [FP_W-1:0]    res_next;

    always_comb
    begin
        e1 = s2_prod_reg[47] ? (s2_e_reg + 11'sd1) : s2_e_reg;
        sig = s2_prod_reg[47] ? s2_prod_reg : (s2_prod_reg << 1);
        normal = (e1 > 11'sd0);
        if (normal)
            sh = 6'd0;
        else if (e1 < -11'sd24)
            sh = 6'd26;
        else
            sh = 6'(11'sd1 - e1);
        shifted = sig >> sh;
        lost_mask = (48'd1 << sh) - 48'd1;
        mant24 = shifted[47:24];
        g = shifted[23];
        st = (|shifted[22:0]) | (|(sig & lost_mask));
        inc = g & (st | mant24[0]);
        mant25 = {1'b0, mant24} + {24'd0, inc};
        base = normal ? 10'(e1 - 11'sd1) : 10'd0;
        // rounding carry ripples into the exponent field
        pack = {1'b0, base, 23'd0} + {9'd0, mant25};
        if (s2_spec_reg)
            res_next = s2_spec_bits_reg;
        else if (pack >= 34'h07F80_0000)
            res_next = {s2_sgn_reg, 8'hFF, 23'd0};
        else
            res_next = {s2_sgn_reg, pack[30:0]};
    end

    logic               s3_valid_reg;
    logic [TAG_W-1:0]   s3_tag_reg;
    logic [FP_W-1:0]    s3_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_tag_reg <= in_tag;
            s1_sgn_reg <= sgn;
            s1_spec_reg <= spec;
            s1_spec_bits_reg <= spec_bits;
            s1_ma_reg <= ma;
            s1_mb_reg <= mb;
            s1_e_reg <= expa + expb - 11'sd127;
            s2_tag_reg <= s1_tag_reg;
            s2_sgn_reg <= s1_sgn_reg;
            s2_spec_reg <= s1_spec_reg;
            s2_spec_bits_reg <= s1_spec_bits_reg;
            s2_prod_reg <= s1_ma_reg * s1_mb_reg;
            s2_e_reg <= s1_e_reg;
            s3_tag_reg <= s2_tag_reg;
            s3_res_reg <= res_next;
        end
    end

    assign res_valid = s3_valid_reg;
    assign res = s3_res_reg;
    assign res_tag = s3_tag_reg;

endmodule

// ===== hdl/int8_dot_8row_row_scaled.sv =====
// int8 dot product over up to eight rows with per-row and per-token fp32 scales
// depends on ids_pkg, ids_cell, ids_fmul
//
// input channel (in_valid / in_stall): mode 0 writes the next row scale, the
// load pointer wraps after ROWS entries; mode 1 is one column: act and one
// weight per row, multiplied and added into each row cell in the same cycle.
// a column with last_col set starts a drain: in_stall stays high while the
// cells shift their sums and scales one row per cycle toward row 0, except
// while the output stalls; sums leave as zero, scales rotate back into place.
// each drained row goes through int-to-float, then two fp32 multipliers of
// three stages each, then the output register: results leave in row order
// from row 0, one row per cycle while the output does not stall.
// output channel (out_valid / out_stall): a stall freezes the whole result
// pipeline and, during the drain, the cell shifts; the held result stays.
// column items run at one per cycle outside a drain; after the last column
// of a vector the input stays stalled until every row has been issued.
// config channel (cfg_valid / cfg_ready): cfg_ready is always high, cfg_data
// writes act_scale.
// reset clears sums, scales, the load pointer, act_scale and all valids.
module int8_dot_8row_row_scaled #(
    parameter int ROWS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic        [ids_pkg::FP_W-1:0]   scale_bits,
    input  logic signed [ids_pkg::W_W-1:0]    act,
    input  logic signed [ids_pkg::W_W-1:0]    w_row0,
    input  logic signed [ids_pkg::W_W-1:0]    w_row1,
    input  logic signed [ids_pkg::W_W-1:0]    w_row2,
    input  logic signed [ids_pkg::W_W-1:0]    w_row3,
    input  logic signed [ids_pkg::W_W-1:0]    w_row4,
    input  logic signed [ids_pkg::W_W-1:0]    w_row5,
    input  logic signed [ids_pkg::W_W-1:0]    w_row6,
    input  logic signed [ids_pkg::W_W-1:0]    w_row7,
    input  logic                              last_col,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic        [ids_pkg::ROW_W-1:0]  row,
    output logic signed [ids_pkg::ACC_W-1:0]  dot,
    output logic        [ids_pkg::FP_W-1:0]   scaled_bits,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic        [ids_pkg::FP_W-1:0]   cfg_data
);
    import ids_pkg::*;

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_DRAIN = 1'b1;
    localparam int   TAG_W    = ROW_W + ACC_W;

    logic               state_reg, state_next;
    logic [ROW_W-1:0]   cnt_reg, cnt_next;
    logic [ROW_W-1:0]   ptr_reg, ptr_next;
    logic [FP_W-1:0]    act_scale_reg;
    logic               in_acc, adv, issue;

    logic signed [W_W-1:0] w_all [MAX_ROWS];
    logic [ACC_W-1:0]      acc_q [ROWS];
    logic [FP_W-1:0]       scale_q [ROWS];

    assign w_all[0] = w_row0;
    assign w_all[1] = w_row1;
    assign w_all[2] = w_row2;
    assign w_all[3] = w_row3;
    assign w_all[4] = w_row4;
    assign w_all[5] = w_row5;
    assign w_all[6] = w_row6;
    assign w_all[7] = w_row7;

    assign in_stall  = (state_reg == ST_DRAIN);
    assign in_acc    = in_valid && !in_stall;
    assign adv       = !out_valid || !out_stall;
    assign issue     = (state_reg == ST_DRAIN) && adv;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        if (in_acc && !mode)
            ptr_next = (ptr_reg == ROW_W'(ROWS - 1)) ? '0 : ptr_reg + 1'b1;
        case (state_reg)
            ST_RUN:
            begin
                if (in_acc && mode && last_col)
                begin
                    state_next = ST_DRAIN;
                    cnt_next = '0;
                end
            end
            ST_DRAIN:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == ROW_W'(ROWS - 1))
                        state_next = ST_RUN;
                end
            end
            default:
                state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            cnt_reg <= '0;
            ptr_reg <= '0;
            act_scale_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
            if (cfg_valid && cfg_ready)
                act_scale_reg <= cfg_data;
        end
    end

    // row cells; row ROWS-1 takes zero sum and row 0's scale when shifting
    genvar gi;
    generate
        for (gi = 0; gi < ROWS; gi++)
        begin : g_cell
            cell_ctrl_t       ctrl;
            logic [ACC_W-1:0] acc_in;
            logic [FP_W-1:0]  scale_in;

            assign ctrl.add   = in_acc && mode;
            assign ctrl.shift = issue;
            assign ctrl.load  = in_acc && !mode && (ptr_reg == ROW_W'(gi));

            if (gi == ROWS - 1)
            begin : g_end
                assign acc_in = '0;
                assign scale_in = scale_q[0];
            end
            else
            begin : g_mid
                assign acc_in = acc_q[gi + 1];
                assign scale_in = scale_q[gi + 1];
            end

            ids_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .act        (act),
                .w          (w_all[gi]),
                .scale_data (scale_bits),
                .acc_in     (acc_in),
                .scale_in   (scale_in),
                .acc        (acc_q[gi]),
                .scale      (scale_q[gi])
            );
        end
    endgenerate

    // int28 to fp32 on the sum leaving row 0
    logic [ACC_W-1:0] d, mag, norm;
    logic [4:0]       lz;
    logic [23:0]      cm;
    logic             cg, cs, cinc;
    logic [FP_W-1:0]  conv;

    always_comb
    begin
        d = acc_q[0];
        mag = d[ACC_W-1] ? (~d + 1'b1) : d;
        lz = lzc28(mag);
        norm = mag << lz;
        cm = norm[27:4];
        cg = norm[3];
        cs = |norm[2:0];
        cinc = cg & (cs | cm[0]);
        if (mag == '0)
            conv = '0;
        else
            conv = {d[ACC_W-1], 31'({8'(8'd153 - {3'd0, lz}), 23'd0} + {7'd0, cm} + {30'd0, cinc})};
    end

    logic             s0_valid_reg;
    logic [FP_W-1:0]  s0_f_reg, s0_scale_reg;
    logic [TAG_W-1:0] s0_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (adv)
            s0_valid_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_f_reg <= conv;
            s0_scale_reg <= scale_q[0];
            s0_tag_reg <= {cnt_reg, acc_q[0]};
        end
    end

    logic             m1_valid, m2_valid;
    logic [FP_W-1:0]  m1_res, m2_res;
    logic [TAG_W-1:0] m1_tag, m2_tag;

    ids_fmul #(.TAG_W(TAG_W)) u_mul_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s0_valid_reg),
        .a         (s0_f_reg),
        .b         (s0_scale_reg),
        .in_tag    (s0_tag_reg),
        .res_valid (m1_valid),
        .res       (m1_res),
        .res_tag   (m1_tag)
    );

    ids_fmul #(.TAG_W(TAG_W)) u_mul_act (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (m1_valid),
        .a         (m1_res),
        .b         (act_scale_reg),
        .in_tag    (m1_tag),
        .res_valid (m2_valid),
        .res       (m2_res),
        .res_tag   (m2_tag)
    );

    logic               out_valid_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ACC_W-1:0]   dot_reg;
    logic [FP_W-1:0]    scaled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= m2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && m2_valid)
        begin
            row_reg <= m2_tag[TAG_W-1:ACC_W];
            dot_reg <= m2_tag[ACC_W-1:0];
            scaled_reg <= m2_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign row         = row_reg;
    assign dot         = dot_reg;
    assign scaled_bits = scaled_reg;
    assign last        = (row_reg == ROW_W'(ROWS - 1));

endmodule

// ===== hdl/ids_chk.sv =====
// port-level checker for the int8 scaled dot block, bound to the top level
// depends on int8_dot_8row_row_scaled_macros.svh
`include "int8_dot_8row_row_scaled_macros.svh"

module ids_chk #(
    parameter int ROWS = 8
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       mode,
    input logic       last_col,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] row,
    input logic       last
);

    `IDS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
    `IDS_ASSERT_NOW(a_last_row, out_valid && last, row == 3'(ROWS - 1), "last flag on wrong row")
    `IDS_ASSERT_NEXT(a_drain_start, in_valid && !in_stall && mode && last_col, in_stall, "no drain after last column")
    `IDS_ASSERT_NEXT(a_row_step, out_valid && !out_stall && !last, !out_valid || row != 3'(ROWS - 1) || $past(row) == 3'(ROWS - 2), "row order broken")

endmodule

bind int8_dot_8row_row_scaled ids_chk #(.ROWS(ROWS)) u_ids_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .last_col  (last_col),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .row       (row),
    .last      (last)
);

// ===== sim/int8_dot_8row_row_scaled_tb.sv =====
// self-checking testbench for int8_dot_8row_row_scaled: directed table, then random vectors
// depends on ids_pkg and the rtl in hdl; fp32 arithmetic is modeled bit-exact in here
module int8_dot_8row_row_scaled_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ids_pkg::*;

    localparam int NROWS     = 8;
    localparam int CYC_LIMIT = 400000;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic                  mode;
        logic [FP_W-1:0]       scale;
        logic [W_W-1:0]        act;
        logic [7:0][W_W-1:0]   w;
        logic                  last_col;
        logic                  typed;      // expected results typed in below
        logic [ACC_W-1:0]      typed_dot;
        logic [FP_W-1:0]       typed_scaled;
    } column_req_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [ACC_W-1:0] dot;
        logic [FP_W-1:0]  scaled;
        logic             last;
    } row_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic mode;
    logic [FP_W-1:0] scale_bits;
    logic signed [W_W-1:0] act;
    logic signed [W_W-1:0] w_row0, w_row1, w_row2, w_row3;
    logic signed [W_W-1:0] w_row4, w_row5, w_row6, w_row7;
    logic last_col;
    logic out_valid;
    logic out_stall;
    logic [ROW_W-1:0] row;
    logic signed [ACC_W-1:0] dot;
    logic [FP_W-1:0] scaled_bits;
    logic last;
    logic cfg_valid;
    logic cfg_ready;
    logic [FP_W-1:0] cfg_data;

    int8_dot_8row_row_scaled #(.ROWS(NROWS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .scale_bits(scale_bits), .act(act),
        .w_row0(w_row0), .w_row1(w_row1), .w_row2(w_row2), .w_row3(w_row3),
        .w_row4(w_row4), .w_row5(w_row5), .w_row6(w_row6), .w_row7(w_row7),
        .last_col(last_col),
        .out_valid(out_valid), .out_stall(out_stall),
        .row(row), .dot(dot), .scaled_bits(scaled_bits), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // predictor state
    logic [ACC_W-1:0] row_sum [NROWS];
    logic [FP_W-1:0]  row_scl [NROWS];
    logic [2:0]       load_ptr;
    logic [FP_W-1:0]  token_scale;

    row_result_t pending_rows [$];
    column_req_t dir_table [$];

    int errors = 0;
    int cycles = 0;
    int send_idle;
    int recv_stall;

    // ---------------- fp32 arithmetic, round to nearest even ----------------

    // value is sgn * mag * 2^scl
    function automatic logic [31:0] fp32_pack(input logic sgn, input logic [47:0] mag,
                                              input int scl);
        int lead, bexp, sh;
        logic [63:0] m, rem, half;
        logic [7:0] efield;
        lead = 0;
        if (mag == 0)
            return {sgn, 31'd0};
        for (int i = 0; i < 48; i++)
        begin
            if (mag[i])
                lead = i;
        end
        bexp = lead + scl + 127;
        if (bexp < 1)
            bexp = 1;
        sh = bexp - 150 - scl;
        if (sh <= 0)
            m = {16'd0, mag} << (-sh);
        else
        begin
            if (sh > 50)
                sh = 50;
            m = {16'd0, mag} >> sh;
            rem = {16'd0, mag} & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && m[0]))
                m = m + 64'd1;
        end
        if (m[24])
        begin
            m = m >> 1;
            bexp = bexp + 1;
        end
        if (bexp >= 255)
            return {sgn, 8'hFF, 23'd0};
        efield = m[23] ? bexp[7:0] : 8'd0;
        return {sgn, efield, m[22:0]};
    endfunction

    function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
        logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
        logic [23:0] ma, mb;
        int ea, eb;
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 0);
        a_zero = (a[30:0] == 0);
        b_zero = (b[30:0] == 0);
        sgn = a[31] ^ b[31];
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
            return FP_QNAN;
        if (a_inf || b_inf)
            return {sgn, 8'hFF, 23'd0};
        ma = {(a[30:23] != 0), a[22:0]};
        mb = {(b[30:23] != 0), b[22:0]};
        ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
        return fp32_pack(sgn, 48'(ma) * 48'(mb), ea + eb - 300);
    endfunction

    function automatic logic [31:0] fp32_from_sum(input logic [ACC_W-1:0] s);
        // one bit wider so the most negative sum negates cleanly
        logic signed [ACC_W:0] v;
        logic [47:0] mag;
        v = {s[ACC_W-1], s};
        mag = (v < 0) ? 48'(-v) : 48'(v);
        return fp32_pack(v < 0, mag, 0);
    endfunction

    // ---------------- predictor ----------------

    function automatic logic [W_W-1:0] weight_of(input column_req_t c, input int r);
        return c.w[r];
    endfunction

    task automatic predict_column(input column_req_t c);
        row_result_t res;
        logic signed [15:0] prod;
        if (!c.mode)
        begin
            row_scl[load_ptr] = c.scale;
            load_ptr = (load_ptr == NROWS - 1) ? 3'd0 : load_ptr + 3'd1;
            return;
        end
        for (int r = 0; r < NROWS; r++)
        begin
            prod = $signed(weight_of(c, r)) * $signed(c.act);
            row_sum[r] = row_sum[r] + ACC_W'(prod);
        end
        if (!c.last_col)
            return;
        for (int r = 0; r < NROWS; r++)
        begin
            res.row = ROW_W'(r);
            res.dot = c.typed ? c.typed_dot : row_sum[r];
            res.scaled = c.typed ? c.typed_scaled
                : fp32_mul(fp32_mul(fp32_from_sum(row_sum[r]), row_scl[r]), token_scale);
            res.last = (r == NROWS - 1);
            pending_rows.push_back(res);
            row_sum[r] = '0;
        end
    endtask

    // ---------------- clock, reset, limit ----------------

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------- receiver ----------------

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall);

    always @(posedge clk)
    begin
        row_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rows.size() == 0)
            begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected result row %0d dot %0d", row, dot);
            end
            else
            begin
                want = pending_rows.pop_front();
                if (row !== want.row || dot !== want.dot || scaled_bits !== want.scaled
                    || last !== want.last)
                begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("mismatch: exp row %0d dot %0d sc %h last %b, got %0d %0d %h %b",
                                 want.row, $signed(want.dot), want.scaled, want.last,
                                 row, dot, scaled_bits, last);
                end
            end
        end
    end

    // ---------------- sender helpers ----------------

    task automatic send_column(input column_req_t c);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        mode = c.mode;
        scale_bits = c.scale;
        act = c.act;
        {w_row7, w_row6, w_row5, w_row4, w_row3, w_row2, w_row1, w_row0} = c.w;
        last_col = c.last_col;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_column(c);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_quiet();
        while (pending_rows.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_act_scale(input logic [FP_W-1:0] v);
        wait_quiet();
        cfg_valid = 1'b1;
        cfg_data = v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        token_scale = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic column_req_t make_col(input logic [7:0] a, input logic [7:0] wv,
                                             input logic lst);
        column_req_t c;
        c = '0;
        c.mode = 1'b1;
        c.act = a;
        c.w = {8{wv}};
        c.last_col = lst;
        return c;
    endfunction

    function automatic column_req_t make_scale(input logic [31:0] s, input logic lst);
        column_req_t c;
        c = '0;
        c.scale = s;
        c.last_col = lst;
        return c;
    endfunction

    function automatic logic [31:0] rand_fp();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(3) != 0)
            v[30:23] = 8'($urandom_range(110, 140));
        return v;
    endfunction

    function automatic column_req_t rand_col(input logic lst);
        column_req_t c;
        c = '0;
        c.mode = 1'b1;
        c.act = 8'($signed($urandom_range(254)) - 127);
        for (int r = 0; r < NROWS; r++)
            c.w[r] = 8'($signed($urandom_range(254)) - 127);
        c.last_col = lst;
        return c;
    endfunction

    // ---------------- stimulus ----------------

    initial
    begin
        column_req_t c;
        int ncols;
        logic [31:0] cfg_vals [6];
        send_idle = 0;
        recv_stall = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = 1'b0;
        scale_bits = '0;
        act = '0;
        {w_row7, w_row6, w_row5, w_row4, w_row3, w_row2, w_row1, w_row0} = '0;
        last_col = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (int r = 0; r < NROWS; r++)
        begin
            row_sum[r] = '0;
            row_scl[r] = '0;
        end
        load_ptr = '0;
        token_scale = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // after reset every scale is zero, so the scaled value is a signed zero
        c = make_col(8'sd127, 8'sd127, 1'b1);
        c.typed = 1'b1; c.typed_dot = 28'd16129; c.typed_scaled = 32'h0000_0000;
        dir_table.push_back(c);
        c = make_col(-8'sd127, 8'sd127, 1'b1);
        c.typed = 1'b1; c.typed_dot = -28'sd16129; c.typed_scaled = 32'h8000_0000;
        dir_table.push_back(c);
        for (int i = 0; i < dir_table.size(); i++)
            send_column(dir_table[i]);
        dir_table.delete();

        write_act_scale(32'h3F80_0000);
        // scales: one, minus two, half, inf, nan, zero, smallest denormal, largest normal
        dir_table.push_back(make_scale(32'h3F80_0000, 1'b0));
        dir_table.push_back(make_scale(32'hC000_0000, 1'b1));   // last_col ignored on a load
        dir_table.push_back(make_scale(32'h3F00_0000, 1'b0));
        dir_table.push_back(make_scale(32'h7F80_0000, 1'b0));
        dir_table.push_back(make_scale(32'h7FA0_0001, 1'b0));
        dir_table.push_back(make_scale(32'h0000_0000, 1'b0));
        dir_table.push_back(make_scale(32'h0000_0001, 1'b0));
        dir_table.push_back(make_scale(32'h7F7F_FFFF, 1'b0));
        dir_table.push_back(make_col(-8'sd127, -8'sd127, 1'b0));
        dir_table.push_back(make_col(8'sd0, 8'sd127, 1'b0));
        dir_table.push_back(make_col(8'sd127, -8'sd127, 1'b0));
        dir_table.push_back(make_col(8'sd1, 8'sd1, 1'b1));
        dir_table.push_back(rand_col(1'b1));
        dir_table.push_back(make_scale(32'h4040_0000, 1'b0));   // pointer wrapped to row 0
        dir_table.push_back(rand_col(1'b0));
        dir_table.push_back(rand_col(1'b1));
        for (int i = 0; i < dir_table.size(); i++)
            send_column(dir_table[i]);

        cfg_vals[0] = 32'h0000_0000;
        cfg_vals[1] = 32'hFFFF_FFFF;
        cfg_vals[2] = 32'h7F80_0000;
        cfg_vals[3] = 32'h0000_0001;
        cfg_vals[4] = 32'h7F7F_FFFF;
        cfg_vals[5] = 32'hBF80_0000;
        for (int k = 0; k < 6; k++)
        begin
            write_act_scale(cfg_vals[k]);
            send_column(rand_col(1'b0));
            send_column(rand_col(1'b1));
        end

        // random part in four idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 48; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 48; end
                default: begin send_idle = 12; recv_stall = 12; end
            endcase
            write_act_scale(rand_fp());
            for (int n = 0; n < 80; )
            begin
                if ($urandom_range(99) < 15)
                begin
                    send_column(make_scale(rand_fp(), 1'($urandom_range(1))));
                    n++;
                end
                else
                begin
                    ncols = ($urandom_range(9) == 0) ? $urandom_range(12, 30)
                                                     : $urandom_range(1, 8);
                    for (int j = 0; j < ncols; j++)
                        send_column(rand_col(j == ncols - 1));
                    n += ncols;
                end
                // in the last phase, hold off until the result pipe runs dry while n is between 40 and 50
                if (ph == 3 && n > 40 && n < 50)
                    wait_quiet();
            end
        end

        while (pending_rows.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== int8_dot_8row_row_scaled.f =====
+incdir+hdl
hdl/ids_pkg.sv
hdl/ids_cell.sv
hdl/ids_fmul.sv
hdl/int8_dot_8row_row_scaled.sv
hdl/ids_chk.sv
sim/int8_dot_8row_row_scaled_tb.sv
